// ----- hdl/byte_stream_tokenizer_unit_assert.svh -----
// Assertion macros shared by the tokenizer modules.
// Needs a clock named aclk and an active-low synchronous reset named aresetn in scope.
`ifndef BYTE_STREAM_TOKENIZER_UNIT_ASSERT_SVH
`define BYTE_STREAM_TOKENIZER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define BST_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define BST_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define BST_ASSERT(label, prop, msg)
`define BST_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// ----- hdl/bst_pkg.sv -----
// Shared types, constants and keyword tables of the byte stream tokenizer.
// No dependencies; used by bst_lexer, bst_outq and byte_stream_tokenizer_unit.
package bst_pkg;

    localparam int MAX_TEXT_LEN = 255;
    localparam int OFFSET_BITS  = 16;

    localparam int LEN_W        = 8;
    localparam int OUT_OFFSET_W = 16;
    localparam int SAT_W        = OFFSET_BITS + OUT_OFFSET_W;
    localparam int LEN_CAP      = (MAX_TEXT_LEN < 255) ? MAX_TEXT_LEN : 255;

    localparam int NUM_KW   = 10;
    localparam int KW_SLOTS = 8;
    localparam int KW_IDX_W = $clog2(KW_SLOTS);

    localparam int OUTQ_DEPTH = 3;
    localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

    typedef enum logic [3:0] {
        TK_NUMBER  = 4'd0,
        TK_IDENT   = 4'd1,
        TK_KEYWORD = 4'd2,
        TK_STRING  = 4'd3,
        TK_OP      = 4'd4,
        TK_EQUALS  = 4'd5,
        TK_SEMI    = 4'd6,
        TK_LPAREN  = 4'd7,
        TK_RPAREN  = 4'd8,
        TK_INVALID = 4'd9,
        TK_UNTERM  = 4'd10,
        TK_END     = 4'd11
    } tok_kind_t;

    typedef struct packed {
        tok_kind_t               kind;
        logic [OUT_OFFSET_W-1:0] start;
        logic [LEN_W-1:0]        len;
        logic                    ovf;
        logic [3:0]              kw;
        logic [7:0]              sym;
        logic                    last;
    } token_t;

    // Keyword spellings, one character per slot, zero padded
    localparam logic [7:0] KW_TEXT [NUM_KW][KW_SLOTS] = '{
        '{"F", "U", "N", "C", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"A", "D", "P", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"S", "T", "R", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"A", "R", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"O", "U", "T", "L", "O", "G", 8'h00, 8'h00},
        '{"O", "U", "T", "W", "A", "R", 8'h00, 8'h00},
        '{"O", "U", "T", "D", "E", "B", 8'h00, 8'h00},
        '{"O", "U", "T", "E", "R", "R", 8'h00, 8'h00},
        '{"V", "A", "R", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"C", "O", "N", "F", "I", "G", 8'h00, 8'h00}
    };

    localparam logic [LEN_W-1:0] KW_LEN [NUM_KW] = '{
        8'd4, 8'd3, 8'd3, 8'd3, 8'd6, 8'd6, 8'd6, 8'd6, 8'd3, 8'd6
    };

    // Clamp an internal offset to the width of the result field
    function automatic logic [OUT_OFFSET_W-1:0] sat_offset(input logic [OFFSET_BITS-1:0] p);
        logic [SAT_W-1:0] wide;
        wide = SAT_W'(p);
        if (wide > SAT_W'({OUT_OFFSET_W{1'b1}})) begin
            return {OUT_OFFSET_W{1'b1}};
        end
        return wide[OUT_OFFSET_W-1:0];
    endfunction

endpackage

// ----- hdl/byte_stream_tokenizer_unit.sv -----
// Byte stream tokenizer: one source byte per transaction in, tokens out.
// Usage:
//   Slave channel s_*: s_tdata[7:0] is the source byte, s_tlast closes the input
//   (a zero byte does the same); both flush any pending token and emit an end token.
//   Master channel m_*: one token per transaction, m_tuser holds the kind,
//   m_tlast marks the final token caused by one input byte.
// Output: a token is registered in the token queue when the byte that completes it is taken.
// Throughput: one byte per cycle while m_tready stays high and each byte yields at most
//   one token; a byte that yields two tokens (one closing a pending token) holds s_tready
//   low until the single result port drains the three-entry token queue to at most one entry.
// Reset: aresetn (synchronous, active low) empties the queue, clears the lexer
//   state and sets the byte position to zero.
// Stall: while m_tready is low, tokens wait in the queue; s_tready drops once fewer
//   than two entries are free and rises again once the receiver has taken enough tokens to free two.
// Depends on bst_pkg, bst_lexer and bst_outq.
module byte_stream_tokenizer_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // end_of_input
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [15:0] start_offset, [23:16] token_length,
                                   // [24] length_overflow, [28:25] keyword_index,
                                   // [36:29] symbol_byte, [39:37] zero
    output logic [3:0]  m_tuser,   // [3:0] token_kind
    output logic        m_tlast    // last_of_run
);

    logic            step;
    logic            push0, push1;
    bst_pkg::token_t res0, res1, head;

    assign step = s_tvalid && s_tready;

    // Classify the byte and update lexer state
    bst_lexer u_lexer (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (step),
        .in_byte      (s_tdata),
        .end_of_input (s_tlast),
        .push0        (push0),
        .push1        (push1),
        .res0         (res0),
        .res1         (res1)
    );

    // Queue tokens toward the result channel
    bst_outq u_outq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push0      (push0),
        .push1      (push1),
        .res0       (res0),
        .res1       (res1),
        .in_ready   (s_tready),
        .head_valid (m_tvalid),
        .head_ready (m_tready),
        .head       (head)
    );

    // Pack the head token onto the master ports
    assign m_tdata = {3'b000, head.sym, head.kw, head.ovf, head.len, head.start};
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

endmodule

// ----- hdl/bst_lexer.sv -----
// Lexer state and per-byte classification: turns one accepted byte into up to two tokens.
// Depends on bst_pkg and byte_stream_tokenizer_unit_assert.svh.
`include "byte_stream_tokenizer_unit_assert.svh"

module bst_lexer (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            step,
    input  logic [7:0]      in_byte,
    input  logic            end_of_input,
    output logic            push0,
    output logic            push1,
    output bst_pkg::token_t res0,
    output bst_pkg::token_t res1
);

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_NUM   = 2'd1,
        MODE_IDENT = 2'd2,
        MODE_STR   = 2'd3
    } lex_mode_t;

    localparam logic [bst_pkg::NUM_KW-1:0] CAND_ALL = {bst_pkg::NUM_KW{1'b1}};
    localparam logic [bst_pkg::OFFSET_BITS-1:0] POS_MAX = {bst_pkg::OFFSET_BITS{1'b1}};

    lex_mode_t                        mode_reg, mode_next;
    logic [bst_pkg::LEN_W-1:0]        len_reg, len_next;
    logic                             ovf_reg, ovf_next;
    logic [bst_pkg::OFFSET_BITS-1:0]  start_reg, start_next;
    logic [bst_pkg::OFFSET_BITS-1:0]  pos_reg, pos_next;
    logic [bst_pkg::NUM_KW-1:0]       cand_reg, cand_next;

    logic                             at_end;
    logic                             is_digit, is_alpha, is_ident, is_space;
    logic [bst_pkg::OFFSET_BITS-1:0]  pos_inc;
    logic                             kw_hit;
    logic [3:0]                       kw_idx;
    bst_pkg::token_t                  pend_tok, idle_tok, end_tok;
    logic                             idle_v, v0, v1;

    // Narrow candidate set by one character at position p
    function automatic logic [bst_pkg::NUM_KW-1:0] track(
        input logic [bst_pkg::NUM_KW-1:0] cand,
        input logic [bst_pkg::LEN_W-1:0]  p,
        input logic [7:0]                 b
    );
        logic [bst_pkg::NUM_KW-1:0] keep;
        for (int k = 0; k < bst_pkg::NUM_KW; k++) begin
            keep[k] = cand[k] && (p < bst_pkg::KW_LEN[k]) &&
                      (bst_pkg::KW_TEXT[k][p[bst_pkg::KW_IDX_W-1:0]] == b);
        end
        return keep;
    endfunction

    // Classify the byte
    always_comb begin
        at_end   = end_of_input || (in_byte == 8'h00);
        is_digit = in_byte inside {["0":"9"]};
        is_alpha = in_byte inside {["A":"Z"], ["a":"z"]};
        is_ident = is_alpha || is_digit || (in_byte == "_");
        is_space = in_byte inside {" ", [8'h09:8'h0D]};
        pos_inc  = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 1'b1;
    end

    // Resolve a keyword match for the pending identifier, first listed wins
    always_comb begin
        kw_hit = 1'b0;
        kw_idx = '0;
        for (int i = bst_pkg::NUM_KW - 1; i >= 0; i--) begin
            if (cand_reg[i] && (bst_pkg::KW_LEN[i] == len_reg)) begin
                kw_hit = 1'b1;
                kw_idx = 4'(i);
            end
        end
        kw_hit = kw_hit && !ovf_reg;
    end

    // Build the pending token and the end token
    always_comb begin
        pend_tok       = '0;
        pend_tok.start = bst_pkg::sat_offset(start_reg);
        pend_tok.len   = len_reg;
        pend_tok.ovf   = ovf_reg;
        case (mode_reg)
            MODE_IDENT: begin
                pend_tok.kind = kw_hit ? bst_pkg::TK_KEYWORD : bst_pkg::TK_IDENT;
                pend_tok.kw   = kw_hit ? kw_idx : 4'd0;
            end
            MODE_STR: pend_tok.kind = bst_pkg::TK_UNTERM;
            default:  pend_tok.kind = bst_pkg::TK_NUMBER;
        endcase

        end_tok       = '0;
        end_tok.kind  = bst_pkg::TK_END;
        end_tok.start = bst_pkg::sat_offset(pos_reg);
    end

    // Next state and results for one byte
    always_comb begin
        mode_next  = mode_reg;
        len_next   = len_reg;
        ovf_next   = ovf_reg;
        start_next = start_reg;
        pos_next   = pos_reg;
        cand_next  = cand_reg;
        res0       = '0;
        res1       = '0;
        v0         = 1'b0;
        v1         = 1'b0;
        idle_tok   = '0;
        idle_v     = 1'b0;

        if (at_end) begin
            // Close what is pending, then the end token; return to reset values
            if (mode_reg != MODE_IDLE) begin
                res0 = pend_tok;
                res1 = end_tok;
                v0   = 1'b1;
                v1   = 1'b1;
            end else begin
                res0 = end_tok;
                v0   = 1'b1;
            end
            mode_next  = MODE_IDLE;
            len_next   = '0;
            ovf_next   = 1'b0;
            start_next = '0;
            pos_next   = '0;
            cand_next  = CAND_ALL;
        end else if (mode_reg == MODE_STR) begin
            if (in_byte == "\"") begin
                res0      = pend_tok;
                res0.kind = bst_pkg::TK_STRING;
                v0        = 1'b1;
                mode_next = MODE_IDLE;
            end else if (len_reg >= bst_pkg::LEN_W'(bst_pkg::LEN_CAP)) begin
                ovf_next = 1'b1;
            end else begin
                len_next = len_reg + 1'b1;
            end
        end else if ((mode_reg == MODE_NUM && is_digit) ||
                     (mode_reg == MODE_IDENT && is_ident)) begin
            // Extend the running number or identifier
            if (mode_reg == MODE_IDENT) begin
                cand_next = track(cand_reg, len_reg, in_byte);
            end
            if (len_reg >= bst_pkg::LEN_W'(bst_pkg::LEN_CAP)) begin
                ovf_next = 1'b1;
            end else begin
                len_next = len_reg + 1'b1;
            end
        end else begin
            // Handle the byte as in idle; a running token is closed first
            mode_next = MODE_IDLE;
            if (is_digit || is_alpha || in_byte == "_" || in_byte == "\"") begin
                start_next = pos_reg;
                len_next   = 8'd1;
                ovf_next   = 1'b0;
                cand_next  = CAND_ALL;
                if (is_digit) begin
                    mode_next = MODE_NUM;
                end else if (in_byte == "\"") begin
                    mode_next  = MODE_STR;
                    start_next = pos_inc;
                    len_next   = '0;
                end else begin
                    mode_next = MODE_IDENT;
                    cand_next = track(CAND_ALL, '0, in_byte);
                end
            end else if (!is_space) begin
                idle_v         = 1'b1;
                idle_tok.start = bst_pkg::sat_offset(pos_reg);
                idle_tok.len   = 8'd1;
                idle_tok.sym   = in_byte;
                case (in_byte)
                    "+", "-", "*", "/": idle_tok.kind = bst_pkg::TK_OP;
                    "=":                idle_tok.kind = bst_pkg::TK_EQUALS;
                    ";":                idle_tok.kind = bst_pkg::TK_SEMI;
                    "(":                idle_tok.kind = bst_pkg::TK_LPAREN;
                    ")":                idle_tok.kind = bst_pkg::TK_RPAREN;
                    default:            idle_tok.kind = bst_pkg::TK_INVALID;
                endcase
            end
            if (mode_reg != MODE_IDLE) begin
                res0 = pend_tok;
                v0   = 1'b1;
                res1 = idle_tok;
                v1   = idle_v;
            end else begin
                res0 = idle_tok;
                v0   = idle_v;
            end
        end

        if (!at_end) begin
            pos_next = pos_inc;
        end

        // Mark the final token of this byte
        res0.last = v0 && !v1;
        res1.last = v1;
    end

    assign push0 = step && v0;
    assign push1 = step && v1;

    // Hold lexer state, advance on each accepted byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            len_reg   <= '0;
            ovf_reg   <= 1'b0;
            start_reg <= '0;
            pos_reg   <= '0;
            cand_reg  <= CAND_ALL;
        end else if (step) begin
            mode_reg  <= mode_next;
            len_reg   <= len_next;
            ovf_reg   <= ovf_next;
            start_reg <= start_next;
            pos_reg   <= pos_next;
            cand_reg  <= cand_next;
        end
    end

    `BST_ASSERT(a_end_resets, (step && at_end) |=> (mode_reg == MODE_IDLE && pos_reg == '0 && cand_reg == CAND_ALL), "end of input did not restore reset state")
    `BST_ASSERT_ALWAYS(a_second_after_first, push1 |-> (push0 && !res0.last && res1.last), "second token without a first one")
    `BST_ASSERT_ALWAYS(a_single_is_last, (push0 && !push1) |-> res0.last, "single token not marked last")

endmodule

// ----- hdl/bst_outq.sv -----
// Three-entry token queue between the lexer and the result channel.
// Depends on bst_pkg and byte_stream_tokenizer_unit_assert.svh.
`include "byte_stream_tokenizer_unit_assert.svh"

module bst_outq (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push0,
    input  logic            push1,
    input  bst_pkg::token_t res0,
    input  bst_pkg::token_t res1,
    output logic            in_ready,
    output logic            head_valid,
    input  logic            head_ready,
    output bst_pkg::token_t head
);

    bst_pkg::token_t                slot_reg  [bst_pkg::OUTQ_DEPTH];
    bst_pkg::token_t                slot_next [bst_pkg::OUTQ_DEPTH];
    logic [bst_pkg::OUTQ_CNT_W-1:0] count_reg, count_next;
    logic [bst_pkg::OUTQ_CNT_W-1:0] base;
    logic                           pop;

    assign head_valid = (count_reg != '0);
    assign head       = slot_reg[0];
    assign pop        = head_valid && head_ready;
    // Room for two tokens is needed before a byte is taken
    assign in_ready   = (count_reg <= bst_pkg::OUTQ_CNT_W'(bst_pkg::OUTQ_DEPTH - 2));

    // Shift on pop, then write new tokens behind the survivors
    always_comb begin
        base = count_reg - bst_pkg::OUTQ_CNT_W'(pop);
        for (int i = 0; i < bst_pkg::OUTQ_DEPTH; i++) begin
            if (pop && i < bst_pkg::OUTQ_DEPTH - 1) begin
                slot_next[i] = slot_reg[i + 1];
            end else begin
                slot_next[i] = slot_reg[i];
            end
            if (push0 && base == bst_pkg::OUTQ_CNT_W'(i)) begin
                slot_next[i] = res0;
            end else if (push1 && base + 1'b1 == bst_pkg::OUTQ_CNT_W'(i)) begin
                slot_next[i] = res1;
            end
        end
        count_next = base + bst_pkg::OUTQ_CNT_W'(push0) + bst_pkg::OUTQ_CNT_W'(push1);
    end

    // Hold the fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // Payload slots carry no reset
    always_ff @(posedge aclk) begin
        for (int i = 0; i < bst_pkg::OUTQ_DEPTH; i++) begin
            slot_reg[i] <= slot_next[i];
        end
    end

    `BST_ASSERT(a_count_bound, count_reg <= bst_pkg::OUTQ_CNT_W'(bst_pkg::OUTQ_DEPTH), "queue count beyond depth")
    `BST_ASSERT(a_no_overrun, push0 |-> (count_reg <= bst_pkg::OUTQ_CNT_W'(bst_pkg::OUTQ_DEPTH - 2)), "push into a full queue")
    `BST_ASSERT(a_pop_drains, (pop && !push0) |=> (count_reg == $past(count_reg) - 1'b1), "pop did not drain one entry")

endmodule
